### rtl/utf8ps_pkg.sv
// ----------------------------------------------------------------------------
// utf8ps_pkg
// Types shared by the paste sanitizer: channel payloads and the byte job
// handed from the decoder to the output sequencer.
// ----------------------------------------------------------------------------
package utf8ps_pkg;

  localparam int unsigned MaxSequence = 4;
  localparam int unsigned IdxW        = $clog2(MaxSequence);

  typedef enum logic {
    KIND_DATA   = 1'b0,
    KIND_FINISH = 1'b1
  } kind_e;

  typedef enum logic {
    STATUS_OK       = 1'b0,
    STATUS_REJECTED = 1'b1
  } status_e;

  typedef struct packed {
    logic       kind;
    logic [7:0] data_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       is_status;
    logic       status_code;
    logic       run_last;
  } out_item_t;

  // One job is one run of results from one input item
  typedef struct packed {
    logic [MaxSequence-1:0][7:0] bytes;
    logic [IdxW-1:0]             last_idx;
    logic                        is_status;
    logic                        status_code;
  } job_t;

endpackage

### rtl/utf8_paste_sanitizer.sv
// Path: an accepted item is written into the job queue, then loaded into the
// output sequencer's job register, from which its first result is offered.
// Throughput: one input item per cycle unless the queue is full; the output side
// sends one result per cycle unless stalled, n results for an n-byte code point.
// The job queue (QUEUE_DEPTH entries) absorbs bursts; input stalls when full.
// Reset (async, active low) clears decoder state, queue and output; no clear pass.
// ----------------------------------------------------------------------------
// utf8_paste_sanitizer
// Strict UTF-8 paste filter: decoder front end, job queue, output sequencer.
// ----------------------------------------------------------------------------
module utf8_paste_sanitizer #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  utf8ps_pkg::in_item_t  in_item_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output utf8ps_pkg::out_item_t out_item_o
);

  utf8ps_pkg::job_t push_job, head_job;
  logic             push, pop, q_full, q_empty, in_accept;

  assign in_stall_o = q_full;
  assign in_accept  = in_valid_i && !q_full;

  utf8ps_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (in_accept),
    .item_i   (in_item_i),
    .push_o   (push),
    .job_o    (push_job)
  );

  utf8ps_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (push_job),
    .pop_i   (pop),
    .full_o  (q_full),
    .empty_o (q_empty),
    .job_o   (head_job)
  );

  utf8ps_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_avail_i (!q_empty),
    .job_i       (head_job),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

endmodule

### rtl/utf8ps_front.sv
// ----------------------------------------------------------------------------
// utf8ps_front
// Decoder: checks strict UTF-8, folds CR/LF, drops control code points other
// than HT, LF and CR, and turns each input item into at most one job for the queue.
// ----------------------------------------------------------------------------
module utf8ps_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                accept_i,
  input  utf8ps_pkg::in_item_t item_i,
  output logic                push_o,
  output utf8ps_pkg::job_t    job_o
);

  localparam logic [7:0] CharHt  = 8'h09;
  localparam logic [7:0] CharLf  = 8'h0A;
  localparam logic [7:0] CharCr  = 8'h0D;
  localparam logic [7:0] CharSp  = 8'h20;
  localparam logic [7:0] CharDel = 8'h7F;

  function automatic logic [2:0] lead_len(input logic [7:0] b);
    logic [2:0] n;
    if (b < 8'h80) n = 3'd1;
    else if (b >= 8'hC2 && b <= 8'hDF) n = 3'd2;
    else if (b >= 8'hE0 && b <= 8'hEF) n = 3'd3;
    else if (b >= 8'hF0 && b <= 8'hF4) n = 3'd4;
    else n = 3'd0;
    return n;
  endfunction

  function automatic logic cont_ok(input logic [7:0] lead, input logic [1:0] pos,
                                   input logic [7:0] b);
    logic [7:0] lo;
    logic [7:0] hi;
    lo = 8'h80;
    hi = 8'hBF;
    if (pos == 2'd1) begin
      if (lead == 8'hE0) lo = 8'hA0;
      else if (lead == 8'hED) hi = 8'h9F;
      else if (lead == 8'hF0) lo = 8'h90;
      else if (lead == 8'hF4) hi = 8'h8F;
    end
    return (b >= lo) && (b <= hi);
  endfunction

  logic [2:0][7:0] held_q;
  logic [1:0]      held_cnt_q, held_cnt_d;
  logic            acr_q, acr_d;
  logic            sticky_q, sticky_d;

  logic [7:0] b;
  logic [2:0] need;
  logic       cp_done;
  logic [1:0] have;
  logic       is_lf, is_cr, is_ht, is_ctl;
  logic       wr_held0, wr_held1, wr_held2;
  logic [utf8ps_pkg::MaxSequence-1:0][7:0] seq;

  assign b = item_i.data_byte;

  always_comb begin
    held_cnt_d = held_cnt_q;
    acr_d      = acr_q;
    sticky_d   = sticky_q;
    need       = lead_len(held_q[0]);
    cp_done    = 1'b0;
    have       = 2'd0;
    wr_held0   = 1'b0;
    wr_held1   = 1'b0;
    wr_held2   = 1'b0;
    push_o     = 1'b0;
    job_o      = '0;

    seq[0] = (held_cnt_q > 2'd0) ? held_q[0] : b;
    seq[1] = (held_cnt_q > 2'd1) ? held_q[1] : b;
    seq[2] = (held_cnt_q > 2'd2) ? held_q[2] : b;
    seq[3] = b;

    // classification only matters for single bytes and the C1 range (C2 80..9F)
    is_lf  = (held_cnt_q == 2'd0) && (b == CharLf);
    is_cr  = (held_cnt_q == 2'd0) && (b == CharCr);
    is_ht  = (held_cnt_q == 2'd0) && (b == CharHt);
    is_ctl = ((held_cnt_q == 2'd0) && (b < CharSp || b == CharDel)) ||
             ((held_cnt_q == 2'd1) && (held_q[0] == 8'hC2) && (b <= 8'h9F));

    if (accept_i) begin
      if (item_i.kind == utf8ps_pkg::KIND_FINISH) begin
        push_o            = 1'b1;
        job_o.is_status   = 1'b1;
        job_o.status_code = (sticky_q || held_cnt_q != 2'd0) ?
                            utf8ps_pkg::STATUS_REJECTED : utf8ps_pkg::STATUS_OK;
        held_cnt_d = 2'd0;
        acr_d      = 1'b0;
        sticky_d   = 1'b0;
      end else if (!sticky_q) begin
        if (held_cnt_q == 2'd0) begin
          unique case (lead_len(b))
            3'd0: sticky_d = 1'b1;
            3'd1: cp_done  = 1'b1;
            default: begin
              wr_held0   = 1'b1;
              held_cnt_d = 2'd1;
            end
          endcase
        end else if (!cont_ok(held_q[0], held_cnt_q, b)) begin
          sticky_d   = 1'b1;
          held_cnt_d = 2'd0;
        end else if ({1'b0, held_cnt_q} + 3'd1 < need) begin
          wr_held1   = (held_cnt_q == 2'd1);
          wr_held2   = (held_cnt_q == 2'd2);
          held_cnt_d = held_cnt_q + 2'd1;
        end else begin
          cp_done    = 1'b1;
          have       = held_cnt_q;
          held_cnt_d = 2'd0;
        end
      end
    end

    if (cp_done) begin
      acr_d = 1'b0;
      if (acr_q && is_lf) begin
        push_o = 1'b0;
      end else if (is_cr) begin
        acr_d          = 1'b1;
        push_o         = 1'b1;
        job_o.bytes[0] = CharLf;
      end else if (is_lf || is_ht) begin
        push_o         = 1'b1;
        job_o.bytes[0] = b;
      end else if (!is_ctl) begin
        push_o         = 1'b1;
        job_o.bytes    = seq;
        job_o.last_idx = have;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_cnt_q <= 2'd0;
      acr_q      <= 1'b0;
      sticky_q   <= 1'b0;
    end else begin
      held_cnt_q <= held_cnt_d;
      acr_q      <= acr_d;
      sticky_q   <= sticky_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_held0) held_q[0] <= b;
    if (wr_held1) held_q[1] <= b;
    if (wr_held2) held_q[2] <= b;
  end

  // an error always drops the partial sequence
  assert property (@(posedge clk_i) disable iff (!rst_ni) sticky_q |-> held_cnt_q == 2'd0)
    else $error("sticky error with bytes still held");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_i && item_i.kind == utf8ps_pkg::KIND_FINISH
    |=> held_cnt_q == 2'd0 && !sticky_q && !acr_q)
    else $error("finish did not clear decoder state");

endmodule

### rtl/utf8ps_fifo.sv
// ----------------------------------------------------------------------------
// utf8ps_fifo
// Small job queue between decoder and output sequencer.
// ----------------------------------------------------------------------------
module utf8ps_fifo #(
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  utf8ps_pkg::job_t job_i,
  input  logic             pop_i,
  output logic             full_o,
  output logic             empty_o,
  output utf8ps_pkg::job_t job_o
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(DEPTH);

  utf8ps_pkg::job_t mem_q [DEPTH];
  logic [PtrW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]  cnt_q;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == FullCnt);
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign job_o   = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
      if (do_pop)  rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
      if (do_push && !do_pop) cnt_q <= cnt_q + 1'b1;
      else if (do_pop && !do_push) cnt_q <= cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_ptr_q] <= job_i;
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) push_i |-> !full_o)
    else $error("job pushed into full queue");

endmodule

### rtl/utf8ps_back.sv
// ----------------------------------------------------------------------------
// utf8ps_back
// Output sequencer: plays one job out as a run of result items.
// ----------------------------------------------------------------------------
module utf8ps_back (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  job_avail_i,
  input  utf8ps_pkg::job_t      job_i,
  output logic                  pop_o,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output utf8ps_pkg::out_item_t out_item_o
);

  utf8ps_pkg::job_t             cur_q;
  logic                         busy_q;
  logic [utf8ps_pkg::IdxW-1:0]  idx_q;
  logic                         fire, at_last;

  assign fire    = busy_q && !out_stall_i;
  assign at_last = (idx_q == cur_q.last_idx);
  assign pop_o   = job_avail_i && (!busy_q || (fire && at_last));

  assign out_valid_o            = busy_q;
  assign out_item_o.out_byte    = cur_q.bytes[idx_q];
  assign out_item_o.is_status   = cur_q.is_status;
  assign out_item_o.status_code = cur_q.status_code;
  assign out_item_o.run_last    = at_last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      idx_q  <= '0;
    end else if (pop_o) begin
      busy_q <= 1'b1;
      idx_q  <= '0;
    end else if (fire) begin
      busy_q <= !at_last;
      idx_q  <= idx_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) cur_q <= job_i;
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) busy_q |-> idx_q <= cur_q.last_idx)
    else $error("result index ran past end of job");

endmodule
